@@ design/hdlc_nrzi_frame_transmitter_assert.svh @@
// Assertion macros shared by the checker of the HDLC NRZI frame transmitter.
// The macros expect signals named clock and reset in the scope where they are used.
`ifndef HDLC_NRZI_FRAME_TRANSMITTER_ASSERT_SVH
`define HDLC_NRZI_FRAME_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HDLCTX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define HDLCTX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/hdlctx_pkg.sv @@
// Types and constants of the HDLC NRZI frame transmitter.
// No dependencies; imported by the top level.
package hdlctx_pkg;

   // Opcodes on the request channel.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_DATA  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCRAMBLE = 2'd0;
   localparam logic [1:0] CSR_PREAMBLE = 2'd1;
   localparam logic [1:0] CSR_CLOSING  = 2'd2;
   localparam logic [1:0] CSR_TAIL     = 2'd3;

   localparam logic [5:0] PREAMBLE_RESET = 6'd50;
   localparam logic [4:0] CLOSING_RESET  = 5'd10;
   localparam logic [4:0] TAIL_RESET     = 5'd10;
   localparam logic [5:0] PREAMBLE_MAX   = 6'd60;
   localparam logic [4:0] CLOSING_MAX    = 5'd24;
   localparam logic [4:0] TAIL_MAX       = 5'd24;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [4:0]  STUFF_RUN = 5'h1F;
   localparam logic [3:0]  FULL_COUNT = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SEND = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   // Which part of the frame the bit coder is working through.
   typedef enum logic [5:0] {
      SEG_PRE   = 6'b000001,
      SEG_DATA  = 6'b000010,
      SEG_CRCLO = 6'b000100,
      SEG_CRCHI = 6'b001000,
      SEG_CLOSE = 6'b010000,
      SEG_TAIL  = 6'b100000
   } seg_type;

endpackage

@@ design/hdlc_nrzi_frame_transmitter.sv @@
// HDLC transmitter: bit stuffing, CRC-16/X.25, optional x^17+x^12+1 scrambler,
// NRZI coding and byte packing through one shared bit coder; depends on hdlctx_pkg.
// One line bit per cycle while the output register is free; the coder stalls while a line
// byte waits in the output register, and each item ends with a wrap-up step in ST_FIN.
// req_tready is high only between items. Synchronous reset clears control, coder state
// and registers to defaults.
module hdlc_nrzi_frame_transmitter
   import hdlctx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] line_byte, [11:8] bit_count, [15:12] zero
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser,   // frame_done
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [5:0]  csr_wdata
);

   state_type   state_ff, state_in;
   seg_type     seg_ff, seg_in;
   logic        scr_en_ff, scr_en_in;
   logic [5:0]  pre_ff, pre_in;
   logic [4:0]  close_ff, close_in;
   logic [4:0]  tail_ff, tail_in;
   logic [15:0] crc_ff, crc_in;
   logic [16:0] scram_ff, scram_in;
   logic        level_ff, level_in;
   logic [4:0]  ones_ff, ones_in;
   logic [7:0]  pack_ff, pack_in;
   logic [2:0]  fill_ff, fill_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  idx_ff, idx_in;
   logic [5:0]  left_ff, left_in;
   logic        stuff_ff, stuff_in;
   logic        is_end_ff, is_end_in;
   logic        pend_v_ff, pend_v_in;
   logic [7:0]  pend_ff, pend_in;
   logic        out_v_ff, out_v_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [3:0]  out_cnt_ff, out_cnt_in;
   logic        out_last_ff, out_last_in;
   logic        out_done_ff, out_done_in;

   logic [5:0]  pre_n;
   logic [4:0]  close_n;
   logic [4:0]  tail_n;
   logic        req_fire;
   logic        out_free;
   logic        enc_bit;
   logic        scr_bit;
   logic        tx_bit;
   logic [4:0]  ones_new;
   logic [16:0] scram_new;
   logic        level_new;
   logic [7:0]  pack_set;
   logic        crc_fb;
   logic        stuffed_seg;
   logic        byte_end;

   assign pre_n   = (pre_ff > PREAMBLE_MAX) ? PREAMBLE_MAX : pre_ff;
   assign close_n = (close_ff > CLOSING_MAX) ? CLOSING_MAX : close_ff;
   assign tail_n  = (tail_ff > TAIL_MAX) ? TAIL_MAX : tail_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_v_ff;

   // Shared bit coder: stuffing history, scrambler, NRZI level and packer.
   assign enc_bit   = stuff_ff ? 1'b0 : shift_ff[0];
   assign ones_new  = {ones_ff[3:0], enc_bit};
   assign scr_bit   = enc_bit ^ scram_ff[16] ^ scram_ff[11];
   assign tx_bit    = scr_en_ff ? scr_bit : enc_bit;
   assign scram_new = scr_en_ff ? {scram_ff[15:0], scr_bit} : scram_ff;
   assign level_new = level_ff ^ ~tx_bit;
   assign pack_set  = pack_ff | (8'(level_new) << fill_ff);
   assign crc_fb    = crc_ff[0] ^ enc_bit;
   assign stuffed_seg = (seg_ff == SEG_DATA) || (seg_ff == SEG_CRCLO) ||
                        (seg_ff == SEG_CRCHI);

   always_comb begin
      state_in    = state_ff;
      seg_in      = seg_ff;
      scr_en_in   = scr_en_ff;
      pre_in      = pre_ff;
      close_in    = close_ff;
      tail_in     = tail_ff;
      crc_in      = crc_ff;
      scram_in    = scram_ff;
      level_in    = level_ff;
      ones_in     = ones_ff;
      pack_in     = pack_ff;
      fill_in     = fill_ff;
      shift_in    = shift_ff;
      idx_in      = idx_ff;
      left_in     = left_ff;
      stuff_in    = stuff_ff;
      is_end_in   = is_end_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_byte_in = out_byte_ff;
      out_cnt_in  = out_cnt_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;
      byte_end    = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            CSR_SCRAMBLE: scr_en_in = csr_wdata[0];
            CSR_PREAMBLE: pre_in    = csr_wdata;
            CSR_CLOSING:  close_in  = csr_wdata[4:0];
            CSR_TAIL:     tail_in   = csr_wdata[4:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in    = 3'd0;
               stuff_in  = 1'b0;
               left_in   = 6'd1;
               is_end_in = 1'b0;
               case (req_tuser)
                  OP_START: begin
                     crc_in   = CRC_INIT;
                     scram_in = '0;
                     level_in = 1'b0;
                     ones_in  = '0;
                     pack_in  = '0;
                     fill_in  = '0;
                     seg_in   = SEG_PRE;
                     shift_in = FLAG_BYTE;
                     left_in  = pre_n;
                     state_in = (pre_n == 6'd0) ? ST_FIN : ST_SEND;
                  end
                  OP_DATA: begin
                     seg_in   = SEG_DATA;
                     shift_in = req_tdata;
                     state_in = ST_SEND;
                  end
                  OP_END: begin
                     seg_in    = SEG_CRCLO;
                     shift_in  = ~crc_ff[7:0];
                     is_end_in = 1'b1;
                     state_in  = ST_SEND;
                  end
                  default: ;
               endcase
            end
         end

         ST_SEND: begin
            if (out_free) begin
               ones_in  = ones_new;
               scram_in = scram_new;
               level_in = level_new;
               if (fill_ff == 3'd7) begin
                  pack_in = '0;
                  fill_in = '0;
                  // A finished byte waits in the pending slot until we know
                  // whether it is the last one of this item.
                  if (pend_v_ff) begin
                     out_v_in    = 1'b1;
                     out_byte_in = pend_ff;
                     out_cnt_in  = FULL_COUNT;
                     out_last_in = 1'b0;
                     out_done_in = 1'b0;
                  end
                  pend_in   = pack_set;
                  pend_v_in = 1'b1;
               end else begin
                  pack_in = pack_set;
                  fill_in = fill_ff + 3'd1;
               end

               if (seg_ff == SEG_DATA && !stuff_ff) begin
                  crc_in = {1'b0, crc_ff[15:1]} ^ (crc_fb ? CRC_POLY : 16'h0000);
               end

               if (stuff_ff) begin
                  stuff_in = 1'b0;
                  byte_end = (idx_ff == 3'd0);
               end else begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  idx_in   = idx_ff + 3'd1;
                  if (stuffed_seg && ones_new == STUFF_RUN) begin
                     stuff_in = 1'b1;
                  end else begin
                     byte_end = (idx_ff == 3'd7);
                  end
               end

               if (byte_end) begin
                  if (left_ff > 6'd1) begin
                     left_in  = left_ff - 6'd1;
                     shift_in = (seg_ff == SEG_TAIL) ? 8'h00 : FLAG_BYTE;
                  end else begin
                     case (seg_ff)
                        SEG_CRCLO: begin
                           seg_in   = SEG_CRCHI;
                           shift_in = ~crc_ff[15:8];
                           left_in  = 6'd1;
                        end
                        SEG_CRCHI: begin
                           if (close_n != 5'd0) begin
                              seg_in   = SEG_CLOSE;
                              shift_in = FLAG_BYTE;
                              left_in  = {1'b0, close_n};
                           end else if (tail_n != 5'd0) begin
                              seg_in   = SEG_TAIL;
                              shift_in = 8'h00;
                              left_in  = {1'b0, tail_n};
                           end else begin
                              state_in = ST_FIN;
                           end
                        end
                        SEG_CLOSE: begin
                           if (tail_n != 5'd0) begin
                              seg_in   = SEG_TAIL;
                              shift_in = 8'h00;
                              left_in  = {1'b0, tail_n};
                           end else begin
                              state_in = ST_FIN;
                           end
                        end
                        default: state_in = ST_FIN;
                     endcase
                  end
               end
            end
         end

         ST_FIN: begin
            if (out_free) begin
               if (pend_v_ff && is_end_ff && fill_ff != 3'd0) begin
                  out_v_in    = 1'b1;
                  out_byte_in = pend_ff;
                  out_cnt_in  = FULL_COUNT;
                  out_last_in = 1'b0;
                  out_done_in = 1'b0;
                  pend_v_in   = 1'b0;
               end else if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_byte_in = pend_ff;
                  out_cnt_in  = FULL_COUNT;
                  out_last_in = 1'b1;
                  out_done_in = is_end_ff;
                  pend_v_in   = 1'b0;
                  state_in    = ST_IDLE;
               end else if (is_end_ff && fill_ff != 3'd0) begin
                  // Flush of the partial line byte closes the frame.
                  out_v_in    = 1'b1;
                  out_byte_in = pack_ff;
                  out_cnt_in  = {1'b0, fill_ff};
                  out_last_in = 1'b1;
                  out_done_in = 1'b1;
                  pack_in     = '0;
                  fill_in     = '0;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seg_ff    <= SEG_PRE;
         scr_en_ff <= 1'b0;
         pre_ff    <= PREAMBLE_RESET;
         close_ff  <= CLOSING_RESET;
         tail_ff   <= TAIL_RESET;
         crc_ff    <= CRC_INIT;
         scram_ff  <= '0;
         level_ff  <= 1'b0;
         ones_ff   <= '0;
         pack_ff   <= '0;
         fill_ff   <= '0;
         idx_ff    <= '0;
         left_ff   <= '0;
         stuff_ff  <= 1'b0;
         is_end_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seg_ff    <= seg_in;
         scr_en_ff <= scr_en_in;
         pre_ff    <= pre_in;
         close_ff  <= close_in;
         tail_ff   <= tail_in;
         crc_ff    <= crc_in;
         scram_ff  <= scram_in;
         level_ff  <= level_in;
         ones_ff   <= ones_in;
         pack_ff   <= pack_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         left_ff   <= left_in;
         stuff_ff  <= stuff_in;
         is_end_ff <= is_end_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      pend_ff     <= pend_in;
      out_byte_ff <= out_byte_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, out_cnt_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

@@ design/hdlctx_checker.sv @@
// Port-level checker for the HDLC NRZI frame transmitter, bound to the top level.
// Depends on hdlc_nrzi_frame_transmitter_assert.svh.
`include "hdlc_nrzi_frame_transmitter_assert.svh"

module hdlctx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // A stalled result beat must hold its payload.
   `HDLCTX_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "result beat changed while stalled")

   // The end of a frame is always the last beat of its item.
   `HDLCTX_ASSERT_NOW(a_done_last, rsp_tvalid && rsp_tuser, rsp_tlast, "frame end without last marker")

   // A short line byte only appears as the closing flush of a frame.
   `HDLCTX_ASSERT_NOW(a_short_flush, rsp_tvalid && rsp_tdata[11:8] != 4'd8, rsp_tlast && rsp_tuser, "partial line byte outside frame flush")

   // Bit count stays between one and eight, and unused bits read as zero.
   `HDLCTX_ASSERT_NOW(a_count_range, rsp_tvalid, rsp_tdata[11:8] != 4'd0 && rsp_tdata[15:12] == 4'd0 && rsp_tdata[11:8] <= 4'd8, "bit count out of range")

endmodule

bind hdlc_nrzi_frame_transmitter hdlctx_checker u_hdlctx_checker (.*);

@@ tb/sv/hdlc_nrzi_frame_transmitter_checker.sv @@
// Scoreboard for the HDLC NRZI frame transmitter: predicts the line bytes of every
// accepted request beat and compares them with the response channel.
// Depends on hdlctx_pkg for opcodes, register indexes and coding constants.
`timescale 1ns / 1ps

module hdlc_nrzi_frame_transmitter_checker
   import hdlctx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [5:0]  csr_wdata,
   output int          mismatch_count,
   output int          lines_waiting,
   output int          lines_checked
);

   typedef struct packed {
      logic [7:0] line_byte;
      logic [3:0] bit_count;
      logic       run_last;
      logic       frame_done;
   } line_beat_type;

   line_beat_type due_lines[$];
   line_beat_type item_lines[$];

   // Register copies.
   logic       scramble_on;
   logic [5:0] preamble_cfg;
   logic [4:0] closing_cfg;
   logic [4:0] tail_cfg;

   // Coder state.
   logic [15:0] fcs_acc;
   logic [16:0] scrambler;
   logic        level;
   logic [4:0]  ones_run;
   logic [7:0]  pack_bits;
   logic [3:0]  pack_fill;

   int mismatches;
   int checked;

   function automatic void clear_coder();
      fcs_acc   = CRC_INIT;
      scrambler = '0;
      level     = 1'b0;
      ones_run  = '0;
      pack_bits = '0;
      pack_fill = '0;
   endfunction

   function automatic void emit_line_bit(input logic raw);
      logic          b;
      line_beat_type beat;
      b = raw;
      // The stuffing history looks at the bits before scrambling.
      ones_run = {ones_run[3:0], raw};
      if (scramble_on) begin
         b = raw ^ scrambler[16] ^ scrambler[11];
         scrambler = {scrambler[15:0], b};
      end
      if (!b) level = ~level;
      pack_bits[pack_fill[2:0]] = level;
      pack_fill++;
      if (pack_fill == FULL_COUNT) begin
         beat.line_byte  = pack_bits;
         beat.bit_count  = FULL_COUNT;
         beat.run_last   = 1'b0;
         beat.frame_done = 1'b0;
         item_lines.push_back(beat);
         pack_bits = '0;
         pack_fill = '0;
      end
   endfunction

   function automatic void emit_octet(input logic [7:0] value, input logic stuffed);
      int i;
      for (i = 0; i < 8; i++) begin
         emit_line_bit(value[i]);
         if (stuffed && ones_run == STUFF_RUN) emit_line_bit(1'b0);
      end
   endfunction

   function automatic void fold_fcs(input logic [7:0] value);
      int   i;
      logic fb;
      for (i = 0; i < 8; i++) begin
         fb = fcs_acc[0] ^ value[i];
         fcs_acc = fcs_acc >> 1;
         if (fb) fcs_acc = fcs_acc ^ CRC_POLY;
      end
   endfunction

   function automatic void encode_item(input logic [1:0] opcode, input logic [7:0] payload);
      int            i;
      int            count;
      logic [15:0]   fcs;
      line_beat_type beat;
      item_lines.delete();
      case (opcode)
         OP_START: begin
            clear_coder();
            count = (preamble_cfg > PREAMBLE_MAX) ? PREAMBLE_MAX : preamble_cfg;
            for (i = 0; i < count; i++) emit_octet(FLAG_BYTE, 1'b0);
         end
         OP_DATA: begin
            fold_fcs(payload);
            emit_octet(payload, 1'b1);
         end
         OP_END: begin
            fcs = ~fcs_acc;
            emit_octet(fcs[7:0], 1'b1);
            emit_octet(fcs[15:8], 1'b1);
            count = (closing_cfg > CLOSING_MAX) ? CLOSING_MAX : closing_cfg;
            for (i = 0; i < count; i++) emit_octet(FLAG_BYTE, 1'b0);
            count = (tail_cfg > TAIL_MAX) ? TAIL_MAX : tail_cfg;
            for (i = 0; i < count; i++) emit_octet(8'h00, 1'b0);
            if (pack_fill != 0) begin
               beat.line_byte  = pack_bits;
               beat.bit_count  = pack_fill;
               beat.run_last   = 1'b0;
               beat.frame_done = 1'b0;
               item_lines.push_back(beat);
               pack_bits = '0;
               pack_fill = '0;
            end
            if (item_lines.size() > 0) begin
               beat = item_lines.pop_back();
               beat.frame_done = 1'b1;
               item_lines.push_back(beat);
            end
         end
         default: ;
      endcase
      if (item_lines.size() > 0) begin
         beat = item_lines.pop_back();
         beat.run_last = 1'b1;
         item_lines.push_back(beat);
      end
      foreach (item_lines[i]) due_lines.push_back(item_lines[i]);
   endfunction

   function automatic int field_diff(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: line beat %s mismatch, expected %0h, got %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      line_beat_type want;
      if (reset) begin
         scramble_on  = 1'b0;
         preamble_cfg = PREAMBLE_RESET;
         closing_cfg  = CLOSING_RESET;
         tail_cfg     = TAIL_RESET;
         clear_coder();
         due_lines.delete();
         mismatches = 0;
         checked    = 0;
      end else begin
         // Responses first, so an unexpected beat cannot consume a fresh prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (due_lines.size() == 0) begin
               $display("%0t: line beat mismatch, expected none, got %0h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = due_lines.pop_front();
               checked++;
               mismatches += field_diff("line_byte", want.line_byte, rsp_tdata[7:0]);
               mismatches += field_diff("bit_count", {4'b0, want.bit_count},
                                        {4'b0, rsp_tdata[11:8]});
               mismatches += field_diff("padding", 8'h00, {4'b0, rsp_tdata[15:12]});
               mismatches += field_diff("run_last", {7'b0, want.run_last}, {7'b0, rsp_tlast});
               mismatches += field_diff("frame_done", {7'b0, want.frame_done},
                                        {7'b0, rsp_tuser});
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_SCRAMBLE: scramble_on  = csr_wdata[0];
               CSR_PREAMBLE: preamble_cfg = csr_wdata;
               CSR_CLOSING:  closing_cfg  = csr_wdata[4:0];
               CSR_TAIL:     tail_cfg     = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) encode_item(req_tuser, req_tdata);
      end
      mismatch_count <= mismatches;
      lines_waiting  <= due_lines.size();
      lines_checked  <= checked;
   end

endmodule

@@ tb/sv/hdlc_nrzi_frame_transmitter_tb.sv @@
// Top of the HDLC NRZI frame transmitter testbench: clock, reset, request and register
// stimulus, response stalls and the verdict. Depends on hdlctx_pkg and the checker module.
`timescale 1ns / 1ps

module hdlc_nrzi_frame_transmitter_tb;
   import hdlctx_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 270;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 600;
   localparam int SETTLE_CYCLES = 30;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [5:0]  csr_wdata = '0;

   int mismatch_count;
   int lines_waiting;
   int lines_checked;
   int beats_sent = 0;
   int frames_closed = 0;
   int settings_used = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   logic hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hdlc_nrzi_frame_transmitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   hdlc_nrzi_frame_transmitter_checker u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .lines_waiting  (lines_waiting),
      .lines_checked  (lines_checked)
   );

   // Sender: bursts of back-to-back beats separated by random gaps.
   task automatic send_beat(input logic [1:0] opcode, input logic [7:0] payload);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opcode;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (opcode != OP_UNUSED) beats_sent++;
      if (opcode == OP_END) frames_closed++;
   endtask

   // Registers change only once every predicted line beat is out and the coder has
   // had time to finish an item that produced no beat.
   task automatic program_regs(input logic [5:0] scr_w, input logic [5:0] pre_w,
                               input logic [5:0] clo_w, input logic [5:0] tail_w);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lines_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SCRAMBLE;
      csr_wdata <= scr_w;
      @(posedge clock);
      csr_addr  <= CSR_PREAMBLE;
      csr_wdata <= pre_w;
      @(posedge clock);
      csr_addr  <= CSR_CLOSING;
      csr_wdata <= clo_w;
      @(posedge clock);
      csr_addr  <= CSR_TAIL;
      csr_wdata <= tail_w;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Mostly well-formed frames; now and then a missing start or end, or a stray beat.
   task automatic send_frame();
      int         payload_len;
      int         k;
      logic [7:0] payload;
      payload_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      if ($urandom_range(0, 19) != 0) send_beat(OP_START, 8'($urandom));
      for (k = 0; k < payload_len; k++) begin
         if ($urandom_range(0, 11) == 0) send_beat(2'($urandom_range(0, 3)), 8'($urandom));
         // Runs of ones and flag patterns exercise the stuffing.
         case ($urandom_range(0, 5))
            0: payload = 8'hFF;
            1: payload = FLAG_BYTE;
            2: payload = ($urandom_range(0, 1) != 0) ? 8'h1F : 8'hF8;
            default: payload = 8'($urandom);
         endcase
         send_beat(OP_DATA, payload);
      end
      if ($urandom_range(0, 19) != 0) send_beat(OP_END, 8'($urandom));
   endtask

   // Receiver: stall patterns of random kind and length, plus one long hold-off
   // while the sender keeps offering beats.
   initial begin
      int mode;
      int stretch;
      int k;
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(20, 200);
         for (k = 0; k < stretch; k++) begin
            @(posedge clock);
            if (!hold_done && beats_sent >= 60 && req_tvalid) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_done = 1'b1;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 1) != 0);
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= (k % 3 == 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int         random_base;
      logic [5:0] scr_w;
      logic [5:0] pre_w;
      logic [5:0] clo_w;
      logic [5:0] tail_w;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: a clean frame with stuffing and flag-like payload.
      send_beat(OP_START, 8'h00);
      send_beat(OP_DATA, 8'h00);
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_DATA, FLAG_BYTE);
      send_beat(OP_DATA, 8'h5A);
      send_beat(OP_END, 8'hFF);
      send_beat(OP_UNUSED, 8'hA5);
      // Out of frame order: data and end with no start.
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_END, 8'h00);

      // Scrambler on, no flags or tail: a start drops a held partial byte and
      // the end flushes one.
      program_regs(6'd1, 6'd0, 6'd0, 6'd0);
      send_beat(OP_START, 8'h00);
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_START, 8'h00);
      send_beat(OP_DATA, 8'h01);
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_END, 8'h00);

      // Counts above range are clamped.
      program_regs(6'd0, 6'd63, 6'd31, 6'd31);
      send_beat(OP_START, 8'h00);
      send_beat(OP_DATA, 8'hAA);
      send_beat(OP_END, 8'h00);

      // Largest legal counts; scramble bit clear with the other data bits set.
      program_regs(6'h3E, 6'd60, 6'd24, 6'd24);
      send_beat(OP_START, 8'h00);
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_END, 8'h00);

      random_base = beats_sent;
      while (beats_sent - random_base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            scr_w = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 7))
               0: pre_w = 6'd63;
               1: pre_w = PREAMBLE_MAX;
               default: pre_w = 6'($urandom_range(0, 4));
            endcase
            case ($urandom_range(0, 7))
               0: clo_w = 6'd31;
               1: clo_w = {1'b0, CLOSING_MAX};
               default: clo_w = 6'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 7))
               0: tail_w = 6'd31;
               1: tail_w = {1'b0, TAIL_MAX};
               default: tail_w = 6'($urandom_range(0, 3));
            endcase
            // Bit 5 is ignored by the five-bit registers but still toggled.
            clo_w[5]  = ($urandom_range(0, 1) != 0);
            tail_w[5] = ($urandom_range(0, 1) != 0);
            program_regs(scr_w, pre_w, clo_w, tail_w);
         end
         send_frame();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lines_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats closing %0d frames under %0d register settings;",
               beats_sent, frames_closed, settings_used + 1);
      $display("checked %0d line beats, with %0d mismatches.", lines_checked, mismatch_count);
      if (mismatch_count == 0 && lines_waiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
